// ----- hdl/ppa_pkg.sv -----
// Shared widths and defaults for the polygon perimeter and area block.
package ppa_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned COORD_WIDTH_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF   = 8;

  // Fixed result widths.
  localparam int unsigned LEN_W   = 40;
  localparam int unsigned AREA_W  = 48;
  localparam int unsigned CROSS_W = 49;

  // Saturation limit of both length sums.
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

endpackage

// ----- hdl/polygon_perimeter_and_area_top.sv -----
// Polygon perimeter and twice-area unit with a shared multiplier and a serial square root.
//
// Vertices arrive one per transaction as signed coordinates, with last_vertex_i set on
// the final one. Each edge after the first vertex makes four passes through the one
// shared multiplier (dx*dx, dy*dy and the two shoelace products), forms and accumulates
// the cross term, runs the square root of COORD_WIDTH + 1 + FRAC_BITS steps, one bit per
// cycle, and ends with the saturating length add. A vertex inside a polygon is not taken
// until the edge before it is done. The last vertex also runs the closing edge back to
// the first vertex and then posts the result. A polygon's first vertex is only stored,
// unless it is also its last. in_stall_o is high whenever the block is not idle: while an
// edge is in progress and while a result is being posted. The result sits in an output
// register, so a new vertex is taken while an earlier result still waits to be collected;
// the block only holds at the end of the next polygon if that result is still stalled.
// Lengths carry FRAC_BITS fraction bits and both sums saturate.
module polygon_perimeter_and_area_top #(
  parameter int unsigned COORD_WIDTH = ppa_pkg::COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = ppa_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [COORD_WIDTH-1:0]  vertex_x_i,
  input  logic signed [COORD_WIDTH-1:0]  vertex_y_i,
  input  logic                           last_vertex_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [ppa_pkg::LEN_W-1:0]      open_length_o,
  output logic [ppa_pkg::LEN_W-1:0]      perimeter_o,
  output logic [ppa_pkg::AREA_W-1:0]     double_area_o
);
  import ppa_pkg::*;

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned OW    = CW + 2;            // multiplier operand width
  localparam int unsigned PW    = 2 * OW;            // product width
  localparam int unsigned TW    = PW + 1;            // cross term width
  localparam int unsigned SW    = 2 * CW + 2;        // dx*dx + dy*dy width
  localparam int unsigned NSTEP = CW + 1 + FRAC_BITS; // root steps, one root bit each
  localparam int unsigned RW    = NSTEP;             // root width
  localparam int unsigned REMW  = RW + 2;            // partial remainder width
  localparam int unsigned RADW  = 2 * NSTEP;         // radicand shift register width
  localparam int unsigned CNTW  = $clog2(NSTEP + 1);
  localparam int unsigned ADDW  = ((LEN_W > RW) ? LEN_W : RW) + 1;
  localparam int unsigned XW    = ((CROSS_W > TW) ? CROSS_W : TW) + 1;

  localparam logic signed [XW-1:0] XHI = {{(XW - CROSS_W + 1){1'b0}}, {(CROSS_W - 1){1'b1}}};
  localparam logic signed [XW-1:0] XLO = ~XHI;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_MDX  = 10'b0000000010,
    S_MDY  = 10'b0000000100,
    S_MAB  = 10'b0000001000,
    S_MBA  = 10'b0000010000,
    S_XSUB = 10'b0000100000,
    S_XACC = 10'b0001000000,
    S_ROOT = 10'b0010000000,
    S_LACC = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // Control state and running sums.
  logic                      have_q;
  logic                      edge_q;     // 0: previous to current, 1: closing edge
  logic                      last_q;
  logic [CNTW-1:0]           cnt_q;
  logic [LEN_W-1:0]          len_sum_q;
  logic signed [CROSS_W-1:0] cross_sum_q;
  logic                      out_valid_q;

  // Datapath registers.
  logic signed [CW-1:0]      first_x_q, first_y_q, prev_x_q, prev_y_q, cur_x_q, cur_y_q;
  logic signed [PW-1:0]      prod_q;
  logic [SW-1:0]             s_q;
  logic signed [TW-1:0]      cr_q;
  logic [RADW-1:0]           rad_q;
  logic [RW-1:0]             root_q;
  logic [REMW-1:0]           rem_q;
  logic [LEN_W-1:0]          perim_q;
  logic signed [CROSS_W-1:0] closed_q;
  logic [LEN_W-1:0]          open_out_q, perim_out_q;
  logic [AREA_W-1:0]         area_out_q;

  logic signed [CW-1:0]      ax, ay, bx, by;
  logic signed [CW:0]        dxs, dys;
  logic [CW:0]               adx, ady;
  logic signed [OW-1:0]      op_a, op_b;
  logic signed [PW-1:0]      mult;
  logic signed [TW-1:0]      term;
  logic signed [XW-1:0]      xsum;
  logic signed [CROSS_W-1:0] xsat;
  logic [1:0]                pair;
  logic [REMW+1:0]           rem_ext;
  logic [REMW+1:0]           trial;
  logic                      ge;
  logic [REMW-1:0]           rem_new;
  logic [RW-1:0]             root_new;
  logic [ADDW-1:0]           lsum;
  logic [LEN_W-1:0]          lsat;
  logic [CROSS_W-1:0]        mag;
  logic [AREA_W-1:0]         area;
  logic                      out_free;
  logic                      root_last;

  // Edge endpoints: the previous vertex to the current one, or the closing edge.
  assign ax = edge_q ? cur_x_q   : prev_x_q;
  assign ay = edge_q ? cur_y_q   : prev_y_q;
  assign bx = edge_q ? first_x_q : cur_x_q;
  assign by = edge_q ? first_y_q : cur_y_q;

  assign dxs = (CW + 1)'(ax) - (CW + 1)'(bx);
  assign dys = (CW + 1)'(ay) - (CW + 1)'(by);
  assign adx = dxs[CW] ? unsigned'(-dxs) : unsigned'(dxs);
  assign ady = dys[CW] ? unsigned'(-dys) : unsigned'(dys);

  // Operand selection for the shared multiplier.
  always_comb begin
    case (state_q)
      S_MDX: begin
        op_a = signed'({1'b0, adx});
        op_b = signed'({1'b0, adx});
      end
      S_MDY: begin
        op_a = signed'({1'b0, ady});
        op_b = signed'({1'b0, ady});
      end
      S_MAB: begin
        op_a = OW'(ax);
        op_b = OW'(by);
      end
      S_MBA: begin
        op_a = OW'(bx);
        op_b = OW'(ay);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign mult = op_a * op_b;

  // Shoelace term and its saturating accumulation.
  assign term = cr_q - TW'(prod_q);
  assign xsum = XW'(cross_sum_q) + XW'(cr_q);
  always_comb begin
    if (xsum > XHI) begin
      xsat = XHI[CROSS_W-1:0];
    end else if (xsum < XLO) begin
      xsat = XLO[CROSS_W-1:0];
    end else begin
      xsat = xsum[CROSS_W-1:0];
    end
  end

  // One step of the restoring square root.
  assign pair     = rad_q[RADW-1 -: 2];
  assign rem_ext  = {rem_q, pair};
  assign trial    = (REMW + 2)'({root_q, 2'b01});
  assign ge       = (rem_ext >= trial);
  assign rem_new  = ge ? REMW'(rem_ext - trial) : REMW'(rem_ext);
  assign root_new = {root_q[RW-2:0], ge};
  assign root_last = (cnt_q == CNTW'(NSTEP - 1));

  // Saturating length add.
  assign lsum = ADDW'(len_sum_q) + ADDW'(root_q);
  assign lsat = (lsum > ADDW'(LEN_MAX)) ? LEN_MAX : lsum[LEN_W-1:0];

  // Magnitude of the closed shoelace sum, clamped to the area width.
  assign mag  = closed_q[CROSS_W-1] ? (~unsigned'(closed_q) + CROSS_W'(1))
                                    : unsigned'(closed_q);
  assign area = mag[CROSS_W-1] ? '1 : mag[AREA_W-1:0];

  assign out_free = !out_valid_q || !out_stall_i;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (!have_q && !last_vertex_i) ? S_IDLE : S_MDX;
        end
      end
      S_MDX:  state_d = S_MDY;
      S_MDY:  state_d = S_MAB;
      S_MAB:  state_d = S_MBA;
      S_MBA:  state_d = S_XSUB;
      S_XSUB: state_d = S_XACC;
      S_XACC: state_d = S_ROOT;
      S_ROOT: begin
        if (root_last) begin
          state_d = S_LACC;
        end
      end
      S_LACC: begin
        if (edge_q) begin
          state_d = S_DONE;
        end else begin
          state_d = last_q ? S_MDX : S_IDLE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers and running sums.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      have_q      <= 1'b0;
      edge_q      <= 1'b0;
      last_q      <= 1'b0;
      cnt_q       <= '0;
      len_sum_q   <= '0;
      cross_sum_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // A posted result replaces one that leaves in the same cycle.
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            last_q <= last_vertex_i;
            if (!have_q) begin
              have_q      <= 1'b1;
              len_sum_q   <= '0;
              cross_sum_q <= '0;
              edge_q      <= 1'b1;
            end else begin
              edge_q <= 1'b0;
            end
          end
        end
        S_XSUB: cnt_q <= '0;
        S_XACC: begin
          if (!edge_q) begin
            cross_sum_q <= xsat;
          end
        end
        S_ROOT: cnt_q <= cnt_q + CNTW'(1);
        S_LACC: begin
          if (!edge_q) begin
            len_sum_q <= lsat;
            edge_q    <= 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            have_q      <= 1'b0;
            len_sum_q   <= '0;
            cross_sum_q <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cur_x_q <= vertex_x_i;
          cur_y_q <= vertex_y_i;
          if (!have_q) begin
            first_x_q <= vertex_x_i;
            first_y_q <= vertex_y_i;
            prev_x_q  <= vertex_x_i;
            prev_y_q  <= vertex_y_i;
          end
        end
      end
      S_MDX: prod_q <= mult;
      S_MDY: begin
        s_q    <= prod_q[SW-1:0];
        prod_q <= mult;
      end
      S_MAB: begin
        s_q    <= s_q + prod_q[SW-1:0];
        prod_q <= mult;
      end
      S_MBA: begin
        cr_q   <= TW'(prod_q);
        prod_q <= mult;
      end
      S_XSUB: begin
        cr_q   <= term;
        rad_q  <= RADW'(s_q) << (2 * FRAC_BITS);
        root_q <= '0;
        rem_q  <= '0;
      end
      S_XACC: begin
        if (edge_q) begin
          closed_q <= xsat;
        end
      end
      S_ROOT: begin
        rad_q  <= rad_q << 2;
        root_q <= root_new;
        rem_q  <= rem_new;
      end
      S_LACC: begin
        if (edge_q) begin
          perim_q <= lsat;
        end else begin
          prev_x_q <= cur_x_q;
          prev_y_q <= cur_y_q;
        end
      end
      S_DONE: begin
        if (out_free) begin
          open_out_q  <= len_sum_q;
          perim_out_q <= perim_q;
          area_out_q  <= area;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign open_length_o = open_out_q;
  assign perimeter_o   = perim_out_q;
  assign double_area_o = area_out_q;

endmodule

// ----- hdl/ppa_checker.sv -----
// Port-level checks for the polygon perimeter and area block, bound to its top level.
module ppa_checker #(
  parameter int unsigned COORD_WIDTH = ppa_pkg::COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = ppa_pkg::FRAC_BITS_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic signed [COORD_WIDTH-1:0] vertex_x_i,
  input logic signed [COORD_WIDTH-1:0] vertex_y_i,
  input logic                          last_vertex_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [ppa_pkg::LEN_W-1:0]     open_length_o,
  input logic [ppa_pkg::LEN_W-1:0]     perimeter_o,
  input logic [ppa_pkg::AREA_W-1:0]    double_area_o
);

  // A vertex that closes a polygon keeps the block busy once it is taken.
  property p_busy_after_edge;
    @(posedge clk_i) disable iff (!rst_ni)
      (in_valid_i && !in_stall_o && last_vertex_i) |=> in_stall_o;
  endproperty
  a_busy_after_edge: assert property (p_busy_after_edge)
    else $error("block took a new transaction right after a last vertex");

  // A new result only appears at the end of an edge computation.
  property p_result_from_work;
    @(posedge clk_i) disable iff (!rst_ni)
      $rose(out_valid_o) |-> $past(in_stall_o);
  endproperty
  a_result_from_work: assert property (p_result_from_work)
    else $error("result appeared without work in progress");

  // Closing the polygon can only add length.
  property p_perimeter_ge_open;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |-> (perimeter_o >= open_length_o);
  endproperty
  a_perimeter_ge_open: assert property (p_perimeter_ge_open)
    else $error("perimeter smaller than open length");

  // A stalled result keeps its value.
  property p_out_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && out_stall_i) |=>
        (out_valid_o && $stable(open_length_o) && $stable(perimeter_o)
         && $stable(double_area_o));
  endproperty
  a_out_hold: assert property (p_out_hold)
    else $error("stalled result changed");

endmodule

bind polygon_perimeter_and_area_top ppa_checker #(
  .COORD_WIDTH(COORD_WIDTH),
  .FRAC_BITS  (FRAC_BITS)
) u_ppa_checker (.*);

// ----- test/polygon_result_checker.sv -----
// Checker that predicts and compares the perimeter and area results of the polygon block.
module polygon_result_checker (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       in_valid_i,
  input  logic                                       in_stall_i,
  input  logic signed [ppa_pkg::COORD_WIDTH_DEF-1:0] vertex_x_i,
  input  logic signed [ppa_pkg::COORD_WIDTH_DEF-1:0] vertex_y_i,
  input  logic                                       last_vertex_i,
  input  logic                                       out_valid_i,
  input  logic                                       out_stall_i,
  input  logic [ppa_pkg::LEN_W-1:0]                  open_length_i,
  input  logic [ppa_pkg::LEN_W-1:0]                  perimeter_i,
  input  logic [ppa_pkg::AREA_W-1:0]                 double_area_i,
  output int unsigned                                fail_count_o,
  output int unsigned                                awaiting_o
);
  import ppa_pkg::*;

  localparam longint CROSS_TOP    = (64'sd1 <<< (AREA_W)) - 64'sd1;
  localparam longint CROSS_BOTTOM = -(64'sd1 <<< (AREA_W));
  localparam logic [AREA_W-1:0] AREA_TOP = '1;

  typedef struct {
    logic [LEN_W-1:0]  open_len;
    logic [LEN_W-1:0]  perim;
    logic [AREA_W-1:0] area;
  } polygon_measure_t;

  // Expected results in the order the block must deliver them.
  polygon_measure_t awaited_measures[$];

  // Running state of the polygon being traced.
  logic signed [COORD_WIDTH_DEF-1:0] start_x, start_y, last_x, last_y;
  logic                              tracing;
  logic [LEN_W-1:0]                  path_len;
  longint                            shoelace;

  // Fixed-point edge length: floor(sqrt(dx^2 + dy^2) * 2^FRAC), found bit by bit.
  function automatic logic [63:0] edge_len(input longint ax, input longint ay,
                                           input longint bx, input longint by);
    longint      dx, dy;
    logic [63:0] scaled, root, trial;
    dx = ax - bx;
    dy = ay - by;
    scaled = 64'(dx * dx + dy * dy) << (2 * FRAC_BITS_DEF);
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= scaled) root = trial;
    end
    return root;
  endfunction

  // Saturating add of one edge to a length sum.
  function automatic logic [LEN_W-1:0] grow_len(input logic [LEN_W-1:0] sum,
                                                input logic [63:0] len);
    logic [63:0] total;
    total = 64'(sum) + len;
    return (total > 64'(LEN_MAX)) ? LEN_MAX : total[LEN_W-1:0];
  endfunction

  // Saturating add of one shoelace cross term.
  function automatic longint grow_shoelace(input longint sum, input longint ax,
                                           input longint ay, input longint bx,
                                           input longint by);
    longint r;
    r = sum + (ax * by - bx * ay);
    if (r > CROSS_TOP) return CROSS_TOP;
    if (r < CROSS_BOTTOM) return CROSS_BOTTOM;
    return r;
  endfunction

  // Advance the predicted state by one vertex and queue a result on the last one.
  task automatic trace_vertex(input logic signed [COORD_WIDTH_DEF-1:0] x,
                              input logic signed [COORD_WIDTH_DEF-1:0] y,
                              input logic closes);
    polygon_measure_t m;
    longint           closed;
    logic [63:0]      mag;
    if (!tracing) begin
      start_x  = x;
      start_y  = y;
      path_len = '0;
      shoelace = 0;
      tracing  = 1'b1;
    end else begin
      path_len = grow_len(path_len, edge_len(last_x, last_y, x, y));
      shoelace = grow_shoelace(shoelace, last_x, last_y, x, y);
    end
    last_x = x;
    last_y = y;
    if (closes) begin
      closed = grow_shoelace(shoelace, x, y, start_x, start_y);
      mag = (closed < 0) ? 64'(-closed) : 64'(closed);
      m.open_len = path_len;
      m.perim    = grow_len(path_len, edge_len(x, y, start_x, start_y));
      m.area     = (mag > 64'(AREA_TOP)) ? AREA_TOP : mag[AREA_W-1:0];
      awaited_measures = {awaited_measures, m};
      tracing  = 1'b0;
      path_len = '0;
      shoelace = 0;
    end
  endtask

  // Sample both channels at each rising edge: results first, then vertices.
  always @(posedge clk_i or negedge rst_ni) begin
    polygon_measure_t want;
    if (!rst_ni) begin
      awaited_measures.delete();
      start_x      = '0;
      start_y      = '0;
      last_x       = '0;
      last_y       = '0;
      tracing      = 1'b0;
      path_len     = '0;
      shoelace     = 0;
      fail_count_o = 0;
      awaiting_o   = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (awaited_measures.size() == 0) begin
          fail_count_o = fail_count_o + 1;
          $display("%0t: unexpected result transaction: open_length %0d perimeter %0d area %0d",
                   $time, open_length_i, perimeter_i, double_area_i);
        end else begin
          want = awaited_measures.pop_front();
          if (open_length_i !== want.open_len) begin
            fail_count_o = fail_count_o + 1;
            $display("%0t: open_length expected %0d actual %0d",
                     $time, want.open_len, open_length_i);
          end
          if (perimeter_i !== want.perim) begin
            fail_count_o = fail_count_o + 1;
            $display("%0t: perimeter expected %0d actual %0d",
                     $time, want.perim, perimeter_i);
          end
          if (double_area_i !== want.area) begin
            fail_count_o = fail_count_o + 1;
            $display("%0t: double_area expected %0d actual %0d",
                     $time, want.area, double_area_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        trace_vertex(vertex_x_i, vertex_y_i, last_vertex_i);
      end
      awaiting_o = awaited_measures.size();
    end
  end

endmodule

// ----- test/tb_polygon_perimeter_and_area_top.sv -----
// Testbench top that drives vertex transactions into the polygon block and reports the verdict.
module tb_polygon_perimeter_and_area_top;
  import ppa_pkg::*;

  logic                               clk_i = 1'b0;
  logic                               rst_ni;
  logic                               in_valid_i;
  logic                               in_stall_o;
  logic signed [COORD_WIDTH_DEF-1:0]  vertex_x_i;
  logic signed [COORD_WIDTH_DEF-1:0]  vertex_y_i;
  logic                               last_vertex_i;
  logic                               out_valid_o;
  logic                               out_stall_i = 1'b0;
  logic [LEN_W-1:0]                   open_length_o;
  logic [LEN_W-1:0]                   perimeter_o;
  logic [AREA_W-1:0]                  double_area_o;
  int unsigned                        fail_count;
  int unsigned                        awaiting;
  logic                               calm = 1'b0;

  polygon_perimeter_and_area_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .vertex_x_i    (vertex_x_i),
    .vertex_y_i    (vertex_y_i),
    .last_vertex_i (last_vertex_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .open_length_o (open_length_o),
    .perimeter_o   (perimeter_o),
    .double_area_o (double_area_o)
  );

  polygon_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .vertex_x_i    (vertex_x_i),
    .vertex_y_i    (vertex_y_i),
    .last_vertex_i (last_vertex_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .open_length_i (open_length_o),
    .perimeter_i   (perimeter_o),
    .double_area_i (double_area_o),
    .fail_count_o  (fail_count),
    .awaiting_o    (awaiting)
  );

  // Clock with a period of 4.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // The result side stalls at random except during the calm stretch.
  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 16);
  end

  // Give up after a generous fixed time.
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  // Present one vertex transaction and hold it until it is accepted.
  task automatic send_vertex(input logic signed [COORD_WIDTH_DEF-1:0] x,
                             input logic signed [COORD_WIDTH_DEF-1:0] y,
                             input logic closes);
    while (!calm && ($urandom_range(99) < 16)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    vertex_x_i    <= x;
    vertex_y_i    <= y;
    last_vertex_i <= closes;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Coordinate source: 1 near the origin, 2 extreme values, any other mode full range.
  function automatic logic signed [COORD_WIDTH_DEF-1:0] pick_coord(input int unsigned mode);
    logic [COORD_WIDTH_DEF-1:0] pool[4];
    pool = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
    case (mode)
      1: begin
        return COORD_WIDTH_DEF'($signed($urandom_range(127)) - 64);
      end
      2: begin
        return pool[$urandom_range(3)];
      end
      default: begin
        return COORD_WIDTH_DEF'($urandom());
      end
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned corners;
    int unsigned mode;
    in_valid_i    = 1'b0;
    vertex_x_i    = '0;
    vertex_y_i    = '0;
    last_vertex_i = 1'b0;
    rst_ni        = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Single-vertex polygons give all-zero results.
    send_vertex(16'sd0, 16'sd0, 1'b1);
    send_vertex(-16'sd32768, 16'sd32767, 1'b1);
    // Longest possible edge, out and back.
    send_vertex(-16'sd32768, -16'sd32768, 1'b0);
    send_vertex(16'sd32767, 16'sd32767, 1'b1);
    // Full-range square, counterclockwise and then clockwise.
    send_vertex(-16'sd32768, -16'sd32768, 1'b0);
    send_vertex(16'sd32767, -16'sd32768, 1'b0);
    send_vertex(16'sd32767, 16'sd32767, 1'b0);
    send_vertex(-16'sd32768, 16'sd32767, 1'b1);
    send_vertex(-16'sd32768, -16'sd32768, 1'b0);
    send_vertex(-16'sd32768, 16'sd32767, 1'b0);
    send_vertex(16'sd32767, 16'sd32767, 1'b0);
    send_vertex(16'sd32767, -16'sd32768, 1'b1);
    // Right triangle with exact edge lengths.
    send_vertex(16'sd0, 16'sd0, 1'b0);
    send_vertex(16'sd3, 16'sd0, 1'b0);
    send_vertex(16'sd0, 16'sd4, 1'b1);
    // Repeated point: zero-length edges and no area.
    send_vertex(16'sd5, 16'sd5, 1'b0);
    send_vertex(16'sd5, 16'sd5, 1'b0);
    send_vertex(16'sd5, 16'sd5, 1'b1);
    // Short diagonal across the origin.
    send_vertex(-16'sd1, -16'sd1, 1'b0);
    send_vertex(16'sd0, 16'sd0, 1'b1);

    // Random polygons, mostly small, now and then a long one.
    sent = 0;
    while (sent < 700) begin
      calm = (sent >= 300) && (sent < 450);
      corners = ($urandom_range(19) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      mode = $urandom_range(3);
      for (int k = 0; k < corners; k++) begin
        send_vertex(pick_coord(mode), pick_coord(mode), k == corners - 1);
      end
      sent = sent + corners;
    end
    in_valid_i <= 1'b0;

    // Drain the outstanding results, then let the block settle.
    while (awaiting != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
